>>> design/dlt645_read_frame_codec_defines.svh
// ----------------------------------------------------------------------------
// dlt645_read_frame_codec_defines
// assertion macros for the read frame codec, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef DLT645_READ_FRAME_CODEC_DEFINES_SVH
`define DLT645_READ_FRAME_CODEC_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("codec assertion failed");
`define DLT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define DLT_ASSERT(lbl, prop)
`define DLT_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

>>> design/dlt645_pkg.sv
// ----------------------------------------------------------------------------
// dlt645_pkg
// shared types, frame constants and helpers of the read frame codec
// ----------------------------------------------------------------------------
package dlt645_pkg;

  localparam int unsigned MAX_RESPONSE = 30;
  localparam int unsigned CNT_W        = $clog2(MAX_RESPONSE + 1);
  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned TAG_W        = 32;
  localparam int unsigned READING_W    = 28;
  localparam int unsigned APB_AW       = 4;
  localparam int unsigned APB_DW       = 64;
  localparam int unsigned FRAME_LEN    = 20;
  localparam int unsigned IDX_W        = 5;

  localparam logic [ADDR_W-1:0] METER_ADDR_RST = 48'hAAAA_AAAA_AAAA;

  // register index taken from paddr above the 8-byte word offset
  localparam logic REG_METER_ADDR = 1'b0;

  localparam logic [7:0] BYTE_WAKE = 8'hFE;
  localparam logic [7:0] BYTE_SOF  = 8'h68;
  localparam logic [7:0] BYTE_CTRL = 8'h11;
  localparam logic [7:0] BYTE_LEN  = 8'h04;
  localparam logic [7:0] BYTE_OFS  = 8'h33;
  localparam logic [7:0] BYTE_EOF  = 8'h16;

  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RX   = 1'b1;

  localparam logic OUT_TX   = 1'b0;
  localparam logic OUT_READ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  localparam logic [1:0] Q_VOLT   = 2'd0;
  localparam logic [1:0] Q_CURR   = 2'd1;
  localparam logic [1:0] Q_POWER  = 2'd2;
  localparam logic [1:0] Q_ENERGY = 2'd3;

  // first response data byte
  localparam logic [CNT_W-1:0] DATA_POS = CNT_W'(14);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TX,
    BK_CALC,
    BK_EMIT
  } bk_state_e;

  // one queued job: a request frame or a finished response
  typedef struct packed {
    logic             is_read;
    logic [TAG_W-1:0] payload;   // tag, or four digit pairs in binary
    logic [1:0]       kind;
    logic [1:0]       status;
  } job_t;

  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    bcd_value = 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
  endfunction

  function automatic logic [2:0] data_len(input logic [1:0] k);
    case (k)
      Q_VOLT:   data_len = 3'd2;
      Q_CURR:   data_len = 3'd3;
      Q_POWER:  data_len = 3'd3;
      Q_ENERGY: data_len = 3'd4;
      default:  data_len = 3'd4;
    endcase
  endfunction

  function automatic logic [2:0] dec_places(input logic [1:0] k);
    case (k)
      Q_VOLT:   dec_places = 3'd1;
      Q_CURR:   dec_places = 3'd3;
      Q_POWER:  dec_places = 3'd4;
      Q_ENERGY: dec_places = 3'd2;
      default:  dec_places = 3'd1;
    endcase
  endfunction

endpackage

>>> design/dlt645_if.sv
// ----------------------------------------------------------------------------
// dlt645_if
// request and result channels of the read frame codec
// ----------------------------------------------------------------------------
interface dlt645_req_if;
  import dlt645_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [TAG_W-1:0] data_tag;
  logic [1:0]       quantity;
  logic [7:0]       rx_byte;
  logic             rx_last;

  modport source (output valid, req_type, data_tag, quantity, rx_byte, rx_last,
                  input ready);
  modport sink   (input valid, req_type, data_tag, quantity, rx_byte, rx_last,
                  output ready);
endinterface

interface dlt645_res_if;
  import dlt645_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 out_kind;
  logic [7:0]           tx_byte;
  logic                 tx_last;
  logic [READING_W-1:0] reading;
  logic [2:0]           decimals;
  logic [1:0]           status;

  modport source (output valid, out_kind, tx_byte, tx_last, reading, decimals, status,
                  input ready);
  modport sink   (input valid, out_kind, tx_byte, tx_last, reading, decimals, status,
                  output ready);
endinterface

>>> design/dlt645_front.sv
// ----------------------------------------------------------------------------
// dlt645_front
// accepts items, tracks the response in flight, queues requests and responses
// ----------------------------------------------------------------------------
module dlt645_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dlt645_req_if.sink             req,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output dlt645_pkg::job_t       q_job_o
);
  import dlt645_pkg::*;

  logic [1:0]       kind_q, kind_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             start_q, start_d;
  logic [7:0]       final_q, final_d;
  logic [7:0]       dig_q [4];
  logic [7:0]       dig_d [4];
  logic             accept;
  logic             counted;
  logic [1:0]       slot;
  logic [CNT_W-1:0] min_len;
  logic [1:0]       status;

  assign req.ready = !q_full_i;
  assign accept    = req.valid && req.ready;
  assign counted   = cnt_q < CNT_W'(MAX_RESPONSE);
  assign slot      = 2'(cnt_q - DATA_POS);
  assign min_len   = DATA_POS + CNT_W'(data_len(kind_q));

  always_comb begin
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    final_d = final_q;
    dig_d   = dig_q;
    if (accept) begin
      if (req.req_type == REQ_SEND) begin
        kind_d  = req.quantity;
        cnt_d   = '0;
        start_d = 1'b0;
        final_d = '0;
      end else if (counted) begin
        if (cnt_q == '0) begin
          start_d = (req.rx_byte == BYTE_SOF);
        end
        if (cnt_q >= DATA_POS && cnt_q < DATA_POS + CNT_W'(4)) begin
          dig_d[slot] = bcd_value(8'(req.rx_byte - BYTE_OFS));
        end
        final_d = req.rx_byte;
        cnt_d   = cnt_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (cnt_d == '0 || !start_d || final_d != BYTE_EOF) begin
      status = ST_FRAME;
    end else if (cnt_d < min_len) begin
      status = ST_SHORT;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    q_push_o = accept && (req.req_type == REQ_SEND || req.rx_last);
    q_job_o  = '0;
    if (req.req_type == REQ_SEND) begin
      q_job_o.is_read = 1'b0;
      q_job_o.payload = req.data_tag;
      q_job_o.kind    = req.quantity;
      q_job_o.status  = ST_OK;
    end else begin
      q_job_o.is_read = 1'b1;
      q_job_o.payload = {dig_d[3], dig_d[2], dig_d[1], dig_d[0]};
      q_job_o.kind    = kind_q;
      q_job_o.status  = status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= Q_VOLT;
      cnt_q   <= '0;
      start_q <= 1'b0;
      final_q <= '0;
    end else if (accept && req.req_type == REQ_RX && req.rx_last) begin
      // response done, collection restarts empty
      cnt_q   <= '0;
      start_q <= 1'b0;
      final_q <= '0;
    end else begin
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      final_q <= final_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

endmodule

>>> design/dlt645_queue.sv
// ----------------------------------------------------------------------------
// dlt645_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module dlt645_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dlt645_pkg::job_t       job_i,
  input  logic                   pop_i,
  output dlt645_pkg::job_t       job_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import dlt645_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

endmodule

>>> design/dlt645_back.sv
// ----------------------------------------------------------------------------
// dlt645_back
// serializes request frames and folds response digits into a reading
// ----------------------------------------------------------------------------
module dlt645_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dlt645_pkg::ADDR_W-1:0] meter_addr_i,
  input  dlt645_pkg::job_t          job_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  dlt645_res_if.source              res
);
  import dlt645_pkg::*;

  bk_state_e            state_q, state_d;
  job_t                 job_q;
  logic [IDX_W-1:0]     idx_q;
  logic [7:0]           sum_q;
  logic [READING_W-1:0] acc_q;
  logic [1:0]           dsel;
  logic [7:0]           digit;
  logic [7:0]           tx_byte;
  logic                 load;
  logic                 emit_tx, emit_rd;

  logic                 out_valid_q, out_valid_d;
  logic                 out_kind_q;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;
  logic [READING_W-1:0] out_read_q;
  logic [2:0]           out_dec_q;
  logic [1:0]           out_st_q;

  assign load  = !out_valid_q || res.ready;
  assign dsel  = idx_q[1:0];
  assign digit = job_q.payload[8*dsel +: 8];

  always_comb begin
    case (idx_q)
      5'd0, 5'd1, 5'd2, 5'd3: tx_byte = BYTE_WAKE;
      5'd4:    tx_byte = BYTE_SOF;
      5'd5:    tx_byte = meter_addr_i[7:0];
      5'd6:    tx_byte = meter_addr_i[15:8];
      5'd7:    tx_byte = meter_addr_i[23:16];
      5'd8:    tx_byte = meter_addr_i[31:24];
      5'd9:    tx_byte = meter_addr_i[39:32];
      5'd10:   tx_byte = meter_addr_i[47:40];
      5'd11:   tx_byte = BYTE_SOF;
      5'd12:   tx_byte = BYTE_CTRL;
      5'd13:   tx_byte = BYTE_LEN;
      // tag goes out reversed, offset added
      5'd14:   tx_byte = job_q.payload[7:0] + BYTE_OFS;
      5'd15:   tx_byte = job_q.payload[15:8] + BYTE_OFS;
      5'd16:   tx_byte = job_q.payload[23:16] + BYTE_OFS;
      5'd17:   tx_byte = job_q.payload[31:24] + BYTE_OFS;
      5'd18:   tx_byte = sum_q;
      5'd19:   tx_byte = BYTE_EOF;
      default: tx_byte = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          if (!job_i.is_read)             state_d = BK_TX;
          else if (job_i.status == ST_OK) state_d = BK_CALC;
          else                            state_d = BK_EMIT;
        end
      end
      BK_TX: begin
        if (load && idx_q == IDX_W'(FRAME_LEN - 1)) state_d = BK_IDLE;
      end
      BK_CALC: begin
        if (dsel == 2'd0) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (load) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o   = (state_q == BK_IDLE) && !empty_i;
    emit_tx = (state_q == BK_TX) && load;
    emit_rd = (state_q == BK_EMIT) && load;
    out_valid_d = out_valid_q;
    if (load) out_valid_d = emit_tx || emit_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      acc_q <= '0;
      sum_q <= '0;
      idx_q <= job_i.is_read ? IDX_W'(data_len(job_i.kind) - 3'd1) : '0;
    end else if (emit_tx) begin
      idx_q <= idx_q + IDX_W'(1);
      if (idx_q >= IDX_W'(4) && idx_q <= IDX_W'(17)) sum_q <= sum_q + tx_byte;
    end else if (state_q == BK_CALC) begin
      // most significant pair first, two decimal digits per step
      acc_q <= READING_W'(acc_q * READING_W'(100)) + READING_W'(digit);
      idx_q <= idx_q - IDX_W'(1);
    end

    if (emit_tx) begin
      out_kind_q <= OUT_TX;
      out_byte_q <= tx_byte;
      out_last_q <= idx_q == IDX_W'(FRAME_LEN - 1);
      out_read_q <= '0;
      out_dec_q  <= '0;
      out_st_q   <= ST_OK;
    end else if (emit_rd) begin
      out_kind_q <= OUT_READ;
      out_byte_q <= '0;
      out_last_q <= 1'b0;
      out_read_q <= (job_q.status == ST_OK) ? acc_q : '0;
      out_dec_q  <= dec_places(job_q.kind);
      out_st_q   <= job_q.status;
    end
  end

  assign res.valid    = out_valid_q;
  assign res.out_kind = out_kind_q;
  assign res.tx_byte  = out_byte_q;
  assign res.tx_last  = out_last_q;
  assign res.reading  = out_read_q;
  assign res.decimals = out_dec_q;
  assign res.status   = out_st_q;

endmodule

>>> design/dlt645_read_frame_codec.sv
// ----------------------------------------------------------------------------
// dlt645_read_frame_codec
// request frame: queued, popped by the back unit, sent as 20 bytes at one
// per cycle while res.ready is high; response: one byte per cycle while
// the queue is not full; reading folded if ok, registered after the last byte
// the back unit sets the rate: it takes a new job only from idle
// reset clears control state but idx_q, and loads the default meter address
// ----------------------------------------------------------------------------
`include "dlt645_read_frame_codec_defines.svh"

module dlt645_read_frame_codec (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dlt645_req_if.sink                    req,
  dlt645_res_if.source                  res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlt645_pkg::APB_AW-1:0] paddr,
  input  logic [dlt645_pkg::APB_DW-1:0] pwdata,
  output logic [dlt645_pkg::APB_DW-1:0] prdata,
  output logic                          pready
);
  import dlt645_pkg::*;

  logic [ADDR_W-1:0] meter_q;
  logic              reg_sel;
  job_t              push_job, head_job;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1:3] == REG_METER_ADDR;
  assign prdata  = reg_sel ? APB_DW'(meter_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_q <= METER_ADDR_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      meter_q <= pwdata[ADDR_W-1:0];
    end
  end

  dlt645_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (push_job)
  );

  dlt645_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dlt645_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .meter_addr_i (meter_q),
    .job_i        (head_job),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .res          (res)
  );

  `DLT_ASSERT_MSG(a_no_push_full, !(q_push && q_full), "job queue overflow")
  `DLT_ASSERT(a_bad_reading_zero, (res.valid && res.out_kind == OUT_READ && res.status != ST_OK) |-> (res.reading == '0))
  `DLT_ASSERT(a_tx_clean, (res.valid && res.out_kind == OUT_TX) |-> (res.status == ST_OK && res.decimals == '0))

endmodule
